@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
// no dependencies; every use expects clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define CHK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// condition in one cycle implies a result in the next
`define CHK_NEXT(label, cond, res, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (res)) \
		else $error(msg);

`endif

@@ rtl/dnd_pkg.sv @@
// types and constants for the dns name decompressor
// no dependencies
package dnd_pkg;

	localparam int STORE_BYTES_DEF = 512;
	localparam int HOP_LIMIT_DEF   = 16;
	localparam int LABEL_MAX       = 63;
	localparam int NAME_MAX        = 255;
	localparam int PTR_W           = 14;

	localparam logic [7:0] PTR_MASK = 8'h3f;
	localparam logic [7:0] DOT_CHAR = 8'h2e;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEN,
		S_LEN_D,
		S_CHR,
		S_CHR_D,
		S_LO,
		S_LO_D,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_HOPS,
		ST_RANGE,
		ST_LONG
	} status_t;

endpackage

@@ rtl/dns_name_decompressor.sv @@
// dns name decompressor: packet byte store and label / pointer walker
// depends on dnd_pkg and assert_macros.svh
`include "assert_macros.svh"

// Usage
//   Request channel (req_valid / req_stall, cmd, offset, write_byte): cmd write
//   stores one byte at offset; cmd decode walks the name at offset.
//   Response channel (rsp_valid / rsp_stall): one result per eight name
//   characters, then a final result with last set, the bytes consumed at the
//   start location and the status (ok, hop limit, out of store, name too long).
// Fetch unit
//   A single byte-fetch unit (address compare, increment, registered store read)
//   serves the whole walk: every byte fetched is read in a fetch state and used
//   in the matching use state. req_stall is high for the whole decode, so no
//   new request is taken until the decode ends.
// Stalls and reset
//   The response register frees when its transfer completes; while it is held
//   the walker waits before emitting. arst_n clears the sequencer and the
//   response valid; the store itself is not cleared and must be written first.
module dns_name_decompressor
	import dnd_pkg::*;
#(
	parameter int STORE_BYTES = STORE_BYTES_DEF,
	parameter int HOP_LIMIT   = HOP_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        cmd,
	input  logic [8:0]  offset,
	input  logic [7:0]  write_byte,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [63:0] chars,
	output logic [3:0]  char_count,
	output logic        last,
	output logic [8:0]  consumed,
	output logic [1:0]  status
);

	localparam int AW   = $clog2(STORE_BYTES);
	localparam int RP_W = ($clog2(STORE_BYTES + 1) > PTR_W) ? $clog2(STORE_BYTES + 1) : PTR_W;
	localparam int HW   = $clog2(HOP_LIMIT + 1);

	state_t state_q, state_d;
	status_t status_q, status_d;

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rd_q;

	logic [RP_W-1:0] rp_q;
	logic [RP_W-1:0] off_ext;
	logic [HW-1:0]   hop_q;
	logic [7:0][7:0] pack_q;
	logic [3:0]      fill_q;
	logic [7:0]      name_len_q;
	logic [8:0]      cons_q;
	logic            jumped_q;
	logic            after_label_q;
	logic [5:0]      rem_q;
	logic [5:0]      hi_q;

	logic            rsp_valid_q;
	logic [7:0][7:0] rsp_chars_q;
	logic [3:0]      rsp_count_q;
	logic            rsp_last_q;
	logic [8:0]      rsp_cons_q;
	status_t         rsp_status_q;

	logic req_take, wr_en, fetch_ok, out_free, hops_out;
	logic fetch_st, rd_en, put_req, put_fail, put_wait, put_do, emit_full, done_out;
	logic status_set, len_adv;
	logic [7:0] put_byte;

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign off_ext   = RP_W'(offset);
	assign wr_en     = req_take && (cmd == CMD_WRITE) && (off_ext < RP_W'(STORE_BYTES));
	// shared bounds check for every fetch
	assign fetch_ok  = rp_q < RP_W'(STORE_BYTES);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign hops_out  = hop_q >= HW'(HOP_LIMIT);

	// control decode
	always_comb begin
		fetch_st = 1'b0;
		put_req  = 1'b0;
		put_byte = rd_q;
		done_out = 1'b0;
		unique case (state_q)
			S_LEN, S_CHR, S_LO: fetch_st = 1'b1;
			S_LEN_D: begin
				// dot between labels, pointer or not
				put_req  = after_label_q && (rd_q != 8'd0);
				put_byte = DOT_CHAR;
			end
			S_CHR_D: put_req = 1'b1;
			S_DONE: done_out = out_free;
			default: ;
		endcase
		rd_en     = fetch_st && fetch_ok;
		put_fail  = put_req && (name_len_q >= 8'(NAME_MAX));
		put_wait  = put_req && !put_fail && fill_q[3] && !out_free;
		put_do    = put_req && !put_fail && !put_wait;
		emit_full = put_do && fill_q[3];
		len_adv   = (state_q == S_LEN_D) && !put_fail && !put_wait;
		status_set = 1'b1;
		status_d   = ST_OK;
		priority if (fetch_st && !fetch_ok) begin
			status_d = ST_RANGE;
		end else if (put_fail) begin
			status_d = ST_LONG;
		end else if ((state_q == S_LO_D) && hops_out) begin
			status_d = ST_HOPS;
		end else begin
			status_set = 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_take && (cmd == CMD_DECODE)) state_d = S_LEN;
			end
			S_LEN: state_d = fetch_ok ? S_LEN_D : S_DONE;
			S_LEN_D: begin
				priority if (put_fail) state_d = S_DONE;
				else if (put_wait) state_d = S_LEN_D;
				else if (rd_q == 8'd0) state_d = S_DONE;
				else if (rd_q <= 8'(LABEL_MAX)) state_d = S_CHR;
				else state_d = S_LO;
			end
			S_CHR: state_d = fetch_ok ? S_CHR_D : S_DONE;
			S_CHR_D: begin
				priority if (put_fail) state_d = S_DONE;
				else if (put_wait) state_d = S_CHR_D;
				else if (rem_q == 6'd1) state_d = S_LEN;
				else state_d = S_CHR;
			end
			S_LO: state_d = fetch_ok ? S_LO_D : S_DONE;
			S_LO_D: state_d = hops_out ? S_DONE : S_LEN;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// packet store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem[off_ext[AW-1:0]] <= write_byte;
		if (rd_en) rd_q <= mem[rp_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			status_q      <= ST_OK;
			rp_q          <= '0;
			hop_q         <= '0;
			pack_q        <= '0;
			fill_q        <= 4'd0;
			name_len_q    <= 8'd0;
			cons_q        <= 9'd0;
			jumped_q      <= 1'b0;
			after_label_q <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_IDLE) && req_take && (cmd == CMD_DECODE)) begin
				rp_q          <= off_ext;
				hop_q         <= '0;
				pack_q        <= '0;
				fill_q        <= 4'd0;
				name_len_q    <= 8'd0;
				cons_q        <= 9'd0;
				jumped_q      <= 1'b0;
				after_label_q <= 1'b0;
				status_q      <= ST_OK;
			end
			if (rd_en) begin
				rp_q <= rp_q + RP_W'(1);
				if (!jumped_q) cons_q <= cons_q + 9'd1;
			end
			if (status_set) status_q <= status_d;
			if (put_do) begin
				name_len_q <= name_len_q + 8'd1;
				if (fill_q[3]) begin
					pack_q    <= 64'(put_byte);
					fill_q    <= 4'd1;
				end else begin
					pack_q[fill_q[2:0]] <= put_byte;
					fill_q <= fill_q + 4'd1;
				end
			end
			if (put_do && (state_q == S_CHR_D) && (rem_q == 6'd1)) after_label_q <= 1'b1;
			if ((state_q == S_LO_D) && !hops_out) begin
				// follow the compression pointer
				hop_q         <= hop_q + HW'(1);
				jumped_q      <= 1'b1;
				after_label_q <= 1'b0;
				rp_q          <= RP_W'({hi_q, rd_q});
			end
			if (emit_full || done_out) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// label counter, pointer high bits and response payload
	always_ff @(posedge clk) begin
		if (len_adv && (rd_q != 8'd0)) begin
			rem_q <= rd_q[5:0];
			hi_q  <= 6'(rd_q & PTR_MASK);
		end else if (put_do && (state_q == S_CHR_D)) begin
			rem_q <= rem_q - 6'd1;
		end
		if (emit_full) begin
			rsp_chars_q  <= pack_q;
			rsp_count_q  <= 4'd8;
			rsp_last_q   <= 1'b0;
			rsp_cons_q   <= 9'd0;
			rsp_status_q <= ST_OK;
		end else if (done_out) begin
			rsp_chars_q  <= pack_q;
			rsp_count_q  <= fill_q;
			rsp_last_q   <= 1'b1;
			rsp_cons_q   <= cons_q;
			rsp_status_q <= status_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign chars      = rsp_chars_q;
	assign char_count = rsp_count_q;
	assign last       = rsp_last_q;
	assign consumed   = rsp_cons_q;
	assign status     = rsp_status_q;

	`CHK(a_mid_full, rsp_valid && !last |-> char_count == 4'd8 && status == ST_OK, "short mid result")
	`CHK(a_len_cap, name_len_q <= 8'(NAME_MAX), "name length past limit")
	`CHK(a_chr_order, state_q == S_CHR_D |-> $past(state_q) == S_CHR || $past(state_q) == S_CHR_D, "char use without fetch")
	`CHK_NEXT(a_decode_start, req_valid && !req_stall && cmd == CMD_DECODE, state_q == S_LEN, "decode not started")
	`CHK_NEXT(a_done_emit, state_q == S_DONE && out_free, rsp_valid && last, "final result missing")

endmodule

@@ bench/tb_dns_name_decompressor.sv @@
`timescale 1ns / 1ps
// testbench for dns_name_decompressor: writes labelled and compressed names into the
// packet store, decodes them and checks every result against a local name walker
// depends on dnd_pkg and the dns_name_decompressor rtl
module tb_dns_name_decompressor;
	import dnd_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int LONG_HOLD    = 600;
	localparam int NAME_AREA_LO = 32;
	localparam int NAME_AREA_HI = 500;
	localparam int PRINT_CAP    = 50;

	typedef struct {
		logic [63:0] chars;
		logic [3:0]  count;
		logic        last;
		logic [8:0]  consumed;
		status_t     status;
	} name_chunk_t;

	class name_ledger;
		bit [7:0]       store [STORE_BYTES_DEF];
		bit             written [STORE_BYTES_DEF];
		name_chunk_t    expected_chunks [$];
		name_chunk_t    walk_out [$];
		int             errors;
		logic [PTR_W:0] rd_ptr;
		logic [4:0]     hops;
		logic [63:0]    pack;
		logic [8:0]     name_len;
		logic [9:0]     used_bytes;
		bit             jumped;
		int             fill;
		bit             touched_blank;

		function bit fetch_byte(output logic [7:0] value);
			value = 8'h00;
			if (rd_ptr >= STORE_BYTES_DEF)
				return 1'b0;
			if (!written[rd_ptr[8:0]])
				touched_blank = 1'b1;
			value = store[rd_ptr[8:0]];
			rd_ptr++;
			// only bytes at the start location count, not those behind a pointer
			if (!jumped)
				used_bytes++;
			return 1'b1;
		endfunction

		function void push_chunk(int n, bit fin, logic [8:0] taken, status_t st);
			name_chunk_t c;
			c.chars    = pack;
			c.count    = 4'(n);
			c.last     = fin;
			c.consumed = taken;
			c.status   = st;
			walk_out.push_back(c);
		endfunction

		function bit put_char(logic [7:0] c);
			if (name_len >= NAME_MAX)
				return 1'b0;
			if (fill == 8) begin
				push_chunk(8, 1'b0, 9'd0, ST_OK);
				pack = '0;
				fill = 0;
			end
			pack[8*fill +: 8] = c;
			fill++;
			name_len++;
			return 1'b1;
		endfunction

		// walks the name at start into walk_out; returns 1 if a never written byte was read
		function bit walk_name(logic [8:0] start);
			logic [7:0] len;
			logic [7:0] chr;
			logic [7:0] lo;
			status_t    st;
			int         i;
			walk_out.delete();
			rd_ptr        = {6'd0, start};
			hops          = '0;
			pack          = '0;
			name_len      = '0;
			used_bytes    = '0;
			jumped        = 1'b0;
			fill          = 0;
			touched_blank = 1'b0;
			st            = ST_OK;
			if (!fetch_byte(len))
				st = ST_RANGE;
			while (st == ST_OK && len != 8'd0) begin
				if (len <= LABEL_MAX) begin
					for (i = 0; i < len && st == ST_OK; i++) begin
						if (!fetch_byte(chr))
							st = ST_RANGE;
						else if (!put_char(chr))
							st = ST_LONG;
					end
					if (st == ST_OK) begin
						// the dot goes in before the next length byte is known to be a pointer
						if (!fetch_byte(len))
							st = ST_RANGE;
						else if (len != 8'd0 && !put_char(DOT_CHAR))
							st = ST_LONG;
					end
				end else if (!fetch_byte(lo)) begin
					st = ST_RANGE;
				end else if (hops >= HOP_LIMIT_DEF) begin
					st = ST_HOPS;
				end else begin
					hops++;
					jumped = 1'b1;
					rd_ptr = (PTR_W + 1)'({len & PTR_MASK, lo});
					if (!fetch_byte(len))
						st = ST_RANGE;
				end
			end
			push_chunk(fill, 1'b1, used_bytes[8:0], st);
			return touched_blank;
		endfunction

		function void note_input(logic c, logic [8:0] o, logic [7:0] b);
			if (c == CMD_WRITE) begin
				store[o]   = b;
				written[o] = 1'b1;
			end else begin
				void'(walk_name(o));
				foreach (walk_out[k])
					expected_chunks.push_back(walk_out[k]);
			end
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= PRINT_CAP)
				$display("MISMATCH at %0t: %s", $realtime, what);
		endtask

		task check_result(logic [63:0] ch, logic [3:0] n, logic fin, logic [8:0] taken,
				logic [1:0] st);
			name_chunk_t want;
			if (expected_chunks.size() == 0) begin
				report_mismatch($sformatf("result with none expected: chars %h count %0d", ch, n));
				return;
			end
			want = expected_chunks.pop_front();
			if (ch !== want.chars)
				report_mismatch($sformatf("chars %h, expected %h", ch, want.chars));
			if (n !== want.count)
				report_mismatch($sformatf("char_count %0d, expected %0d", n, want.count));
			if (fin !== want.last)
				report_mismatch($sformatf("last %b, expected %b", fin, want.last));
			if (taken !== want.consumed)
				report_mismatch($sformatf("consumed %0d, expected %0d", taken, want.consumed));
			if (st !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
		endtask
	endclass

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        req_valid  = 1'b0;
	logic        req_stall;
	logic        cmd        = CMD_WRITE;
	logic [8:0]  offset     = '0;
	logic [7:0]  write_byte = '0;
	logic        rsp_valid;
	logic        rsp_stall  = 1'b0;
	logic [63:0] chars;
	logic [3:0]  char_count;
	logic        last;
	logic [8:0]  consumed;
	logic [1:0]  status;

	name_ledger  ledger = new();
	int          send_gap_pct = 25;
	int          rsp_hold_pct = 76;
	bit          hold_ask     = 1'b0;
	int          hold_left    = 0;
	int          cycle_count  = 0;
	int          items_sent   = 0;
	int          decodes_sent = 0;
	int          alloc_at     = NAME_AREA_LO;
	int          phase;
	logic [8:0]  name_starts [$];

	dns_name_decompressor i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.offset     (offset),
		.write_byte (write_byte),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.chars      (chars),
		.char_count (char_count),
		.last       (last),
		.consumed   (consumed),
		.status     (status)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stalls, or one long hold-off when asked
	always @(negedge clk) begin
		if (hold_ask) begin
			hold_ask  = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else
			rsp_stall <= ($urandom_range(99, 0) < rsp_hold_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			ledger.check_result(chars, char_count, last, consumed, status);
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic offer_item(logic c, logic [8:0] o, logic [7:0] b);
		if ($urandom_range(99, 0) < send_gap_pct) begin
			req_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99, 0) < send_gap_pct);
		end
		req_valid  <= 1'b1;
		cmd        <= c;
		offset     <= o;
		write_byte <= b;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		ledger.note_input(c, o, b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic store_byte(logic [8:0] o, logic [7:0] b);
		offer_item(CMD_WRITE, o, b);
	endtask

	task automatic decode_at(logic [8:0] o);
		offer_item(CMD_DECODE, o, 8'($urandom));
		decodes_sent++;
	endtask

	task automatic run_directed();
		int k;
		// pointer to itself: loops until the hop limit
		store_byte(9'd0, 8'hc0);
		store_byte(9'd1, 8'h00);
		// pointer to the top of the 14-bit range, far past the store
		store_byte(9'd2, 8'hff);
		store_byte(9'd3, 8'hff);
		// root name
		store_byte(9'd4, 8'h00);
		// lowest pointer value in the last byte: its low half lies past the end
		store_byte(9'd511, 8'h40);
		// label pointing back at itself: the name outgrows its limit before the hop limit
		store_byte(9'd8, 8'd15);
		for (k = 0; k < 15; k++)
			store_byte(9'(9 + k), (k == 0) ? 8'hff : 8'(8'h61 + k));
		store_byte(9'd24, 8'hc0);
		store_byte(9'd25, 8'h08);
		decode_at(9'd0);
		decode_at(9'd2);
		decode_at(9'd4);
		decode_at(9'd511);
		decode_at(9'd8);
	endtask

	task automatic build_name();
		int         labels;
		int         n;
		int         k;
		logic [7:0] len;
		logic [8:0] start;
		logic [8:0] target;
		if (alloc_at + 200 > NAME_AREA_HI)
			alloc_at = NAME_AREA_LO;
		start  = 9'(alloc_at);
		labels = $urandom_range(3, 0);
		for (n = 0; n < labels; n++) begin
			// mostly short labels, now and then one of the longest
			len = ($urandom_range(9, 0) == 0) ? 8'(LABEL_MAX) : 8'($urandom_range(6, 1));
			store_byte(9'(alloc_at), len);
			alloc_at++;
			for (k = 0; k < len; k++) begin
				store_byte(9'(alloc_at), 8'($urandom_range(255, 0)));
				alloc_at++;
			end
		end
		if (name_starts.size() != 0 && $urandom_range(1, 0) == 1) begin
			target = name_starts[$urandom_range(name_starts.size() - 1, 0)];
			store_byte(9'(alloc_at), {2'($urandom_range(3, 1)), 5'd0, target[8]});
			store_byte(9'(alloc_at + 1), target[7:0]);
			alloc_at += 2;
		end else begin
			store_byte(9'(alloc_at), 8'h00);
			alloc_at++;
		end
		name_starts.push_back(start);
		if (!ledger.walk_name(start))
			decode_at(start);
	endtask

	task automatic random_step();
		int         pick;
		logic [8:0] a;
		pick = $urandom_range(9, 0);
		if (pick < 3 || name_starts.size() == 0)
			build_name();
		else if (pick < 8) begin
			a = name_starts[$urandom_range(name_starts.size() - 1, 0)];
			// earlier names may have been overwritten since
			if (!ledger.walk_name(a))
				decode_at(a);
		end else if (pick == 8)
			store_byte(9'($urandom_range(511, 0)), 8'($urandom_range(255, 0)));
		else begin
			// arbitrary start, often in the middle of a label
			a = 9'($urandom_range(511, 0));
			if (!ledger.walk_name(a))
				decode_at(a);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_directed();
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_gap_pct = 25;
					rsp_hold_pct = 76;
				end
				1: begin
					send_gap_pct = 76;
					rsp_hold_pct = 25;
				end
				default: begin
					send_gap_pct = 0;
					rsp_hold_pct = 0;
					// long hold-off so the walker backs up and stalls new transfers
					hold_ask = 1'b1;
				end
			endcase
			while (decodes_sent < 4 * (phase + 1) || items_sent < 40 * (phase + 1))
				random_step();
		end
		req_valid <= 1'b0;
		while (ledger.expected_chunks.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (ledger.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
